// ===== hdl/wfba_pkg.sv =====
package wfba_pkg;

	// Table geometry
	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_WIDTH = 16;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LIM_W      = $clog2(MAX_BLOCKS + 1);

	// Stream field widths
	localparam int CFG_W  = 5;
	localparam int BLK_W  = 4;
	localparam int FLD_W  = 16;
	localparam int REQ_W  = 16;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 40;

	// Command queue between front and back, depth is a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Item kinds on the op field
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	typedef struct packed {
		logic                  alloc;
		logic                  wr_en;
		logic [IDX_W-1:0]      idx;
		logic [SIZE_WIDTH-1:0] size;
	} cmd_t;

endpackage

// ===== hdl/wfba_front.sv =====
module wfba_front
	import wfba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [0:0]       s_tuser,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	cmd_t              q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [BLK_W-1:0]  in_idx;
	logic [FLD_W-1:0]  in_size;
	cmd_t              in_cmd;
	logic              push;
	logic              pop;

	assign in_idx  = s_tdata[BLK_W-1:0];
	assign in_size = s_tdata[BLK_W+FLD_W-1:BLK_W];

	// Classify: a load outside the table writes nothing but still clears the counter
	always_comb begin
		in_cmd.alloc = (s_tuser[0] == OP_ALLOC);
		in_cmd.wr_en = (s_tuser[0] == OP_LOAD) && (int'(in_idx) < MAX_BLOCKS);
		in_cmd.idx   = IDX_W'(in_idx);
		in_cmd.size  = SIZE_WIDTH'(in_size);
	end

	assign s_tready  = (count_q != QCNT_W'(QDEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("command queue over capacity");

	a_push_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

endmodule

// ===== hdl/wfba_back.sv =====
module wfba_back
	import wfba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LIM_W-1:0] lim,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic [0:0]       m_tuser
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]            state_q;
	logic [SIZE_WIDTH-1:0] mem_q [MAX_BLOCKS];
	logic [IDX_W-1:0]      scan_q;
	logic [LIM_W-1:0]      lim_q;
	logic [SIZE_WIDTH-1:0] size_q;
	logic [REQ_W-1:0]      req_cnt_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [SIZE_WIDTH-1:0] best_val_q;
	logic [SIZE_WIDTH-1:0] rd_data_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  rd_vld_s1;
	logic                  out_valid_q;
	logic                  out_granted_q;
	logic [BLK_W-1:0]      out_block_q;
	logic [FLD_W-1:0]      out_remain_q;
	logic [REQ_W-1:0]      out_req_q;
	logic                  pop;
	logic                  out_free;
	logic                  finish;
	logic                  last_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [SIZE_WIDTH-1:0] wr_data;
	logic [SIZE_WIDTH-1:0] remain;

	assign cmd_ready = (state_q == ST_IDLE);
	assign pop       = cmd_valid && cmd_ready;
	assign out_free  = !out_valid_q || m_tready;
	assign finish    = (state_q == ST_FINISH) && out_free;
	assign last_addr = ((LIM_W'(scan_q) + 1'b1) == lim_q);
	assign remain    = best_val_q - size_q;

	// Single write port: loads from idle, grant updates from finish
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd.idx;
		wr_data = cmd.size;
		if (pop && !cmd.alloc && cmd.wr_en) begin
			wr_en = 1'b1;
		end else if (finish && found_q) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = remain;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[scan_q];
		rd_idx_s1  <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			lim_q     <= '0;
			size_q    <= '0;
			req_cnt_q <= '0;
			found_q   <= 1'b0;
			best_idx_q <= '0;
			best_val_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (!cmd.alloc) begin
							req_cnt_q <= '0;
						end else begin
							req_cnt_q  <= req_cnt_q + 1'b1;
							size_q     <= cmd.size;
							lim_q      <= lim;
							scan_q     <= '0;
							found_q    <= 1'b0;
							best_idx_q <= '0;
							best_val_q <= '0;
							state_q    <= (lim == '0) ? ST_FINISH : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_addr) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Keep the largest fitting size, lowest index on ties
			if (rd_vld_s1 && (rd_data_s1 >= size_q) &&
			    (!found_q || (rd_data_s1 > best_val_q))) begin
				found_q    <= 1'b1;
				best_idx_q <= rd_idx_s1;
				best_val_q <= rd_data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_granted_q <= found_q;
			out_block_q   <= found_q ? BLK_W'(best_idx_q) : '0;
			out_remain_q  <= found_q ? FLD_W'(remain) : '0;
			out_req_q     <= req_cnt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_granted_q;
	assign m_tdata  = {{(OUT_W - BLK_W - FLD_W - REQ_W){1'b0}},
		out_req_q, out_remain_q, out_block_q};

	a_not_granted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_granted_q) |-> (out_block_q == '0 && out_remain_q == '0))
		else $error("refused request carries block or size");

	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_val_q >= size_q))
		else $error("best block smaller than request");

	a_scan_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> rd_vld_s1)
		else $error("scan address issued without read data");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (LIM_W'(scan_q) < lim_q))
		else $error("scan past block count");

endmodule

// ===== hdl/worst_fit_block_allocator_top.sv =====
// Load item: handled as it leaves the queue, no result; the back end takes items only when idle.
// Allocate item: back-end steps dequeue, N reads, drain, finish, N = min(block_count, 16);
//   from dequeue straight to finish when block_count is 0; result valid the cycle after finish.
// A two-entry request queue lets new items arrive while a scan is running.
// arst_n clears control, queue, request counter and sets block_count to 16;
//   the size table is not cleared and must be loaded before use.
module worst_fit_block_allocator_top
	import wfba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Request stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [3:0] block_index, [19:4] size_value, [23:20] zero
	input  logic [0:0]       s_tuser,   // [0] op
	// Result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [3:0] chosen_block, [19:4] remaining_size,
	                                    // [35:20] request_number, [39:36] zero
	output logic [0:0]       m_tuser,   // [0] granted
	// Configuration: block_count
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] block_count_q;
	logic [LIM_W-1:0] lim;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;

	// Take a configuration write on any cycle; the user must issue it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			block_count_q <= cfg_data;
		end
	end

	// Saturate the search span to the table depth
	always_comb begin
		if (int'(block_count_q) > MAX_BLOCKS) begin
			lim = LIM_W'(MAX_BLOCKS);
		end else begin
			lim = LIM_W'(block_count_q);
		end
	end

	// Front end: accept, classify, queue each request
	wfba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back end: table writes, worst-fit scan, grant update, result register
	wfba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lim       (lim),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import wfba_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 8;
	// Loads give no result, so after the last grant the core may still be
	// writing queued loads: two queue entries plus a full scan is well below this.
	localparam int SETTLE_CYCLES = 40;
	// Longest legal silence is the receiver hold-off plus a sender gap.
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 115;
	localparam int NUM_PHASES    = 9;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		bit             granted;
		bit [BLK_W-1:0] block;
		bit [FLD_W-1:0] remaining;
		bit [REQ_W-1:0] number;
	} grant_t;

	// Shadow of the size table and request counter; predicts one grant per
	// allocate request and holds the grants the block still owes us.
	class grant_tracker;
		bit [SIZE_WIDTH-1:0] free_size [MAX_BLOCKS];
		bit [REQ_W-1:0]      req_count;
		int unsigned         block_limit;
		grant_t              pending_grants [$];
		int unsigned         mismatches;
		int unsigned         checked;
		int unsigned         granted_cnt;
		int unsigned         refused_cnt;
		int unsigned         loads;
		int unsigned         allocs;

		function new();
			req_count   = '0;
			block_limit = MAX_BLOCKS;
			mismatches  = 0;
			checked     = 0;
			granted_cnt = 0;
			refused_cnt = 0;
			loads       = 0;
			allocs      = 0;
		endfunction

		// Counts above the table size saturate.
		function void set_block_count(bit [CFG_W-1:0] value);
			block_limit = (value > MAX_BLOCKS) ? MAX_BLOCKS : value;
		endfunction

		function void note_request(logic op, bit [BLK_W-1:0] idx, bit [FLD_W-1:0] size);
			grant_t         g;
			bit [IDX_W-1:0] best;
			bit             found;
			if (op == OP_LOAD) begin
				if (idx < MAX_BLOCKS)
					free_size[idx] = size;
				req_count = '0;
				loads++;
				return;
			end
			allocs++;
			req_count++;
			best  = '0;
			found = 1'b0;
			// Largest fitting block; strict compare keeps the lowest index on ties.
			for (int j = 0; j < block_limit; j++) begin
				if (free_size[IDX_W'(j)] >= size
						&& (!found || free_size[IDX_W'(j)] > free_size[best])) begin
					best  = IDX_W'(j);
					found = 1'b1;
				end
			end
			g.granted   = found;
			g.block     = '0;
			g.remaining = '0;
			g.number    = req_count;
			if (found) begin
				free_size[best] = free_size[best] - size;
				g.block         = BLK_W'(best);
				g.remaining     = free_size[best];
			end
			pending_grants.push_back(g);
		endfunction

		function void check_grant(logic granted, logic [BLK_W-1:0] block,
				logic [FLD_W-1:0] remaining, logic [REQ_W-1:0] number);
			grant_t want;
			checked++;
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected result: granted=%0d block=%0d remaining=%0d number=%0d",
						$realtime, granted, block, remaining, number);
				return;
			end
			want = pending_grants.pop_front();
			if (want.granted)
				granted_cnt++;
			else
				refused_cnt++;
			if (granted !== want.granted || block !== want.block
					|| remaining !== want.remaining || number !== want.number) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("[%0t] result mismatch on request %0d", $realtime, want.number);
					$display("    expected granted=%0d block=%0d remaining=%0d number=%0d",
						want.granted, want.block, want.remaining, want.number);
					$display("    actual   granted=%0d block=%0d remaining=%0d number=%0d",
						granted, block, remaining, number);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic [0:0]       s_tuser   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0]       m_tuser;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	bit               hold_off_pending = 1'b0;
	int unsigned      quiet_cycles     = 0;
	int unsigned      settings_seen    = 0;
	grant_tracker     grants           = new();

	worst_fit_block_allocator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Load sizes: some copy a live entry so that ties between blocks show up.
	function automatic bit [FLD_W-1:0] pick_load_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return grants.free_size[IDX_W'($urandom_range(0, MAX_BLOCKS - 1))];
		if (r < 30)
			return FLD_W'($urandom_range(16'hF000, 16'hFFFF));
		if (r < 50)
			return FLD_W'($urandom_range(0, 255));
		return FLD_W'($urandom_range(0, 16'hFFFF));
	endfunction

	// Request sizes: mostly small enough to be granted, plus zero, full scale and noise.
	function automatic bit [FLD_W-1:0] pick_request_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 22)
			return 16'hFFFF;
		if (r < 30)
			return FLD_W'($urandom_range(16'hF000, 16'hFFFF));
		if (r < 75)
			return FLD_W'($urandom_range(1, 2047));
		return FLD_W'($urandom_range(0, 16'hFFFF));
	endfunction

	// Offer one request, hold it until taken, then maybe idle the sender.
	task automatic send_request(logic op, bit [BLK_W-1:0] idx, bit [FLD_W-1:0] size);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_W - BLK_W - FLD_W){1'b0}}, size, idx};
		do @(posedge clk); while (!s_tready);
		grants.note_request(op, idx, size);
		gap = gap_length();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_block_count(bit [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		grants.set_block_count(value);
		settings_seen++;
	endtask

	// Stop offering, wait for every owed grant, then let trailing loads retire.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (grants.pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One setting of block_count: refill part of the table, then mostly allocate.
	task automatic run_phase(bit [CFG_W-1:0] count, bit squeeze);
		drain();
		write_block_count(count);
		if (squeeze)
			hold_off_pending = 1'b1;
		for (int i = 0; i < MAX_BLOCKS; i++)
			if ($urandom_range(0, 1))
				send_request(OP_LOAD, i[BLK_W-1:0], pick_load_size());
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 12)
				send_request(OP_LOAD, BLK_W'($urandom_range(0, MAX_BLOCKS - 1)),
					pick_load_size());
			else
				send_request(OP_ALLOC, BLK_W'($urandom_range(0, MAX_BLOCKS - 1)),
					pick_request_size());
		end
	endtask

	// Stimulus
	initial begin
		bit [FLD_W-1:0] seed;
		bit [CFG_W-1:0] count;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every block before the first scan: two equal maxima at 1 and 3,
		// an empty block, alternating bit patterns, the rest modest.
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			case (i)
				0:       seed = 16'd100;
				1, 3:    seed = 16'hFFFF;
				2:       seed = 16'h0000;
				4:       seed = 16'h5555;
				5:       seed = 16'hAAAA;
				default: seed = FLD_W'(i * 997);
			endcase
			send_request(OP_LOAD, i[BLK_W-1:0], seed);
		end
		// Reset block_count still applies here.
		send_request(OP_ALLOC, 4'hF, 16'h0000);   // zero request: largest block, unchanged
		send_request(OP_ALLOC, 4'h0, 16'hFFFF);   // tie resolves to the lower block
		send_request(OP_ALLOC, 4'h0, 16'hFFFF);   // then the other full block
		send_request(OP_ALLOC, 4'h0, 16'hFFFF);   // nothing that large left
		send_request(OP_ALLOC, 4'h0, 16'h0001);
		send_request(OP_LOAD,  4'h2, 16'h0007);   // load restarts the request numbering
		send_request(OP_ALLOC, 4'h0, 16'hFFFF);
		send_request(OP_ALLOC, 4'hA, 16'h0005);

		// With no block in the search every request is refused.
		drain();
		write_block_count(5'd0);
		repeat (3)
			send_request(OP_ALLOC, BLK_W'($urandom_range(0, MAX_BLOCKS - 1)),
				pick_request_size());

		// Random phases: oversize, small and full-table counts first, then random.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       count = 5'd31;
				1:       count = 5'd1;
				2:       count = 5'd17;
				3:       count = 5'd2;
				4:       count = 5'd0;
				5:       count = 5'd16;
				default: count = CFG_W'($urandom_range(0, 31));
			endcase
			run_phase(count, p == 2 || p == 6);
		end

		drain();
		$display("Sent %0d requests (%0d loads, %0d allocations) over %0d block_count settings.",
			grants.loads + grants.allocs, grants.loads, grants.allocs, settings_seen);
		$display("Checked %0d results: %0d granted, %0d refused, %0d mismatches.",
			grants.checked, grants.granted_cnt, grants.refused_cnt, grants.mismatches);
		if (grants.mismatches == 0 && grants.pending_grants.size() == 0) begin
			$display("worst_fit_block_allocator_top regression: pass");
		end else begin
			$display("worst_fit_block_allocator_top regression: fail");
		end
		$finish;
	end

	// Result side: random stalls, occasional long open stretches, and a long
	// hold-off whenever a phase requests one, so the queue backs up into the request port.
	initial begin
		int unsigned r;
		@(posedge arst_n);
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else if (r < 60) begin
					m_tready <= 1'b1;
					repeat (100) @(posedge clk);
				end else if (r < 92) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	// Check results and watch for a hang; values seen here are the ones the
	// block sampled at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				grants.check_grant(m_tuser[0], m_tdata[BLK_W-1:0],
					m_tdata[BLK_W+FLD_W-1:BLK_W],
					m_tdata[BLK_W+FLD_W+REQ_W-1:BLK_W+FLD_W]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("[%0t] no handshake for %0d cycles, %0d results still owed",
						$realtime, quiet_cycles, grants.pending_grants.size());
					$display("worst_fit_block_allocator_top regression: fail");
					$finish;
				end
			end
		end
	end

endmodule

// ===== worst_fit_block_allocator_top.f =====
hdl/wfba_pkg.sv
hdl/wfba_front.sv
hdl/wfba_back.sv
hdl/worst_fit_block_allocator_top.sv
sim/testbench.sv
